@@ rtl/core/ipp_pkg.sv @@
// Shared types, codes and the opcode decode table for the instruction predecoder.
package ipp_pkg;

	localparam int ADDRESS_BITS_DEF = 16;

	localparam logic [4:0] M_NONE  = 5'd0;
	localparam logic [4:0] M_IMM   = 5'd1;
	localparam logic [4:0] M_DIR   = 5'd2;
	localparam logic [4:0] M_IDX   = 5'd3;
	localparam logic [4:0] M_DIMM  = 5'd4;
	localparam logic [4:0] M_XIMM  = 5'd5;
	localparam logic [4:0] M_DD    = 5'd6;
	localparam logic [4:0] M_IND   = 5'd7;
	localparam logic [4:0] M_RDIR  = 5'd8;
	localparam logic [4:0] M_RIDX  = 5'd9;
	localparam logic [4:0] M_RDIMM = 5'd10;
	localparam logic [4:0] M_RXIMM = 5'd11;
	localparam logic [4:0] M_FLAG  = 5'd12;
	localparam logic [4:0] M_RET   = 5'd13;
	localparam logic [4:0] M_ABS   = 5'd14;
	localparam logic [4:0] M_RJMP  = 5'd15;
	localparam logic [4:0] M_RCALL = 5'd16;

	localparam logic [7:0] OP_AND_F       = 8'h70;
	localparam logic [7:0] OP_OR_F        = 8'h71;
	localparam logic [7:0] OP_MOV_REG_IMM = 8'h62;
	localparam logic [7:0] FOLD_BASE      = 8'h78;
	localparam logic [7:0] REG_CUR_PP     = 8'hd0;
	localparam logic [7:0] REG_STK_PP     = 8'hd1;
	localparam logic [7:0] REG_IDX_PP     = 8'hd3;

	localparam int TABLE_DEPTH = 136;

	typedef struct packed {
		logic [3:0] cyc;
		logic [1:0] len;
		logic [4:0] mode;
	} dec_entry_t;

	typedef struct packed {
		logic [15:0] instr_address;
		logic [7:0]  opcode_byte;
		logic [7:0]  operand_one;
		logic [7:0]  operand_two;
	} instr_t;

	typedef struct packed {
		logic [1:0]  instr_length;
		logic [3:0]  cycle_count;
		logic [4:0]  operand_mode;
		logic [15:0] first_address;
		logic [15:0] second_address;
		logic [7:0]  immediate_value;
		logic        register_bank;
		logic [15:0] jump_target;
		logic [1:0]  page_mode;
		logic        page_mode_changed;
	} result_t;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] current_page;
		logic [7:0] stack_page;
		logic [7:0] index_page;
	} page_state_t;

	typedef struct packed {
		logic       flag_we;
		logic [7:0] flag_nxt;
		logic       cur_we;
		logic       stk_we;
		logic       idx_we;
		logic [7:0] page_val;
	} state_upd_t;

	localparam dec_entry_t DEC_TABLE [0:TABLE_DEPTH-1] = '{
		'{4'd15,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd4,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd4,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd5,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd5,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd11,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd9,2'd1,M_NONE}, '{4'd4,2'd2,M_IMM}, '{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd9,2'd3,M_DIMM}, '{4'd10,2'd3,M_XIMM},
		'{4'd5,2'd2,M_IMM}, '{4'd5,2'd2,M_IMM}, '{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX},
		'{4'd8,2'd3,M_DIMM}, '{4'd9,2'd3,M_XIMM}, '{4'd10,2'd2,M_IND}, '{4'd10,2'd2,M_IND},
		'{4'd4,2'd1,M_NONE}, '{4'd9,2'd3,M_RDIMM}, '{4'd10,2'd3,M_RXIMM},
		'{4'd9,2'd3,M_RDIMM}, '{4'd10,2'd3,M_RXIMM}, '{4'd9,2'd3,M_RDIMM},
		'{4'd10,2'd3,M_RXIMM}, '{4'd7,2'd3,M_DIMM},
		'{4'd9,2'd3,M_XIMM}, '{4'd9,2'd3,M_RDIMM}, '{4'd10,2'd3,M_RXIMM}, '{4'd5,2'd1,M_NONE},
		'{4'd7,2'd2,M_DIR}, '{4'd7,2'd2,M_DIR}, '{4'd5,2'd1,M_NONE}, '{4'd4,2'd1,M_NONE},
		'{4'd4,2'd2,M_IMM}, '{4'd5,2'd2,M_DIR}, '{4'd6,2'd2,M_IDX}, '{4'd5,2'd2,M_DIR},
		'{4'd6,2'd2,M_IDX}, '{4'd8,2'd3,M_DIMM}, '{4'd9,2'd3,M_XIMM}, '{4'd4,2'd2,M_IMM},
		'{4'd6,2'd2,M_DIR}, '{4'd7,2'd2,M_IDX}, '{4'd5,2'd2,M_DIR}, '{4'd4,2'd1,M_NONE},
		'{4'd4,2'd1,M_NONE}, '{4'd6,2'd2,M_RDIR}, '{4'd7,2'd2,M_RIDX}, '{4'd10,2'd3,M_DD},
		'{4'd5,2'd2,M_RDIR}, '{4'd6,2'd2,M_RIDX}, '{4'd8,2'd3,M_RDIMM}, '{4'd9,2'd3,M_RXIMM},
		'{4'd4,2'd1,M_NONE}, '{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd4,2'd1,M_NONE},
		'{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX}, '{4'd4,2'd1,M_NONE}, '{4'd7,2'd2,M_DIR},
		'{4'd8,2'd2,M_IDX}, '{4'd4,2'd1,M_NONE}, '{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX},
		'{4'd4,2'd2,M_FLAG}, '{4'd4,2'd2,M_FLAG}, '{4'd4,2'd2,M_FLAG}, '{4'd4,2'd1,M_NONE},
		'{4'd4,2'd1,M_NONE}, '{4'd4,2'd1,M_NONE}, '{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX},
		'{4'd4,2'd1,M_NONE}, '{4'd4,2'd1,M_NONE}, '{4'd7,2'd2,M_DIR}, '{4'd8,2'd2,M_IDX},
		'{4'd13,2'd3,M_ABS}, '{4'd7,2'd3,M_ABS}, '{4'd10,2'd1,M_RET}, '{4'd8,2'd1,M_RET},
		'{4'd5,2'd2,M_RJMP}, '{4'd11,2'd2,M_RCALL}, '{4'd5,2'd2,M_RJMP}, '{4'd5,2'd2,M_RJMP},
		'{4'd5,2'd2,M_RJMP}, '{4'd5,2'd2,M_RJMP}, '{4'd7,2'd2,M_RJMP}, '{4'd13,2'd2,M_RCALL}
	};

endpackage

@@ rtl/core/instruction_predecode_paging.sv @@
// Top level of the instruction predecoder with RAM paging.
// Usage:
//   Input channel instr_valid/instr_stall carries one instruction per
//   transaction: opcode address and up to three bytes. Output channel
//   result_valid/result_stall carries one decoded result per instruction,
//   in order.
//   An accepted instruction is held in an input register, decoded by one
//   level of table lookup, small adds and muxing, and written into the
//   result register, from which it is offered on the output channel. One
//   instruction per cycle is sustained while result_stall stays low; the
//   flag byte and page pointers update in the same edge that writes the
//   result, so the next instruction in line sees them.
//   When result_stall is high with a result waiting, the result register
//   holds, one more instruction is accepted into the input register, and
//   instr_stall rises until the output drains.
//   Reset clears both valid flags, the flag byte and all page pointers.
module instruction_predecode_paging #(
	parameter int ADDRESS_BITS = ipp_pkg::ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  logic [15:0] instr_address,
	input  logic [7:0]  opcode_byte,
	input  logic [7:0]  operand_one,
	input  logic [7:0]  operand_two,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  instr_length,
	output logic [3:0]  cycle_count,
	output logic [4:0]  operand_mode,
	output logic [15:0] first_address,
	output logic [15:0] second_address,
	output logic [7:0]  immediate_value,
	output logic        register_bank,
	output logic [15:0] jump_target,
	output logic [1:0]  page_mode,
	output logic        page_mode_changed
);
	import ipp_pkg::*;

	logic        valid_s1;
	instr_t      instr_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res_nxt;
	state_upd_t  upd;
	page_state_t st;
	logic        adv_s2;
	logic        fire;
	logic        take;

	assign adv_s2 = !valid_s2 || !result_stall;
	assign fire = valid_s1 && adv_s2;
	assign instr_stall = valid_s1 && !adv_s2;
	assign take = instr_valid && !instr_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!instr_stall) begin
				valid_s1 <= instr_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			instr_s1 <= '{instr_address, opcode_byte, operand_one, operand_two};
		end
		if (fire) begin
			res_s2 <= res_nxt;
		end
	end

	ipp_decode #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_decode (
		.instr(instr_s1),
		.st   (st),
		.res  (res_nxt),
		.upd  (upd)
	);

	ipp_state u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.upd   (upd),
		.st    (st)
	);

	assign result_valid = valid_s2;
	assign instr_length = res_s2.instr_length;
	assign cycle_count = res_s2.cycle_count;
	assign operand_mode = res_s2.operand_mode;
	assign first_address = res_s2.first_address;
	assign second_address = res_s2.second_address;
	assign immediate_value = res_s2.immediate_value;
	assign register_bank = res_s2.register_bank;
	assign jump_target = res_s2.jump_target;
	assign page_mode = res_s2.page_mode;
	assign page_mode_changed = res_s2.page_mode_changed;

endmodule

@@ rtl/core/ipp_decode.sv @@
// Combinational decode: table lookup, paged operand addresses, targets and state updates.
module ipp_decode #(
	parameter int ADDRESS_BITS = ipp_pkg::ADDRESS_BITS_DEF
) (
	input  ipp_pkg::instr_t      instr,
	input  ipp_pkg::page_state_t st,
	output ipp_pkg::result_t     res,
	output ipp_pkg::state_upd_t  upd
);
	import ipp_pkg::*;

	localparam logic [16:0] AMASK_W = (17'd1 << ADDRESS_BITS) - 17'd1;
	localparam logic [15:0] AMASK = AMASK_W[15:0];

	logic [7:0]  tbl_idx;
	dec_entry_t  ent;
	logic [1:0]  pm;
	logic        xio;
	logic [7:0]  dpage;
	logic [7:0]  xpage;
	logic [7:0]  nf;
	logic [11:0] raw;
	logic [15:0] rel_sum;
	logic [15:0] inc;

	assign tbl_idx = instr.opcode_byte[7] ? (FOLD_BASE + {4'h0, instr.opcode_byte[7:4]})
		: instr.opcode_byte;
	assign ent = DEC_TABLE[tbl_idx];
	assign pm = st.flag_byte[7:6];
	assign xio = st.flag_byte[4];
	assign dpage = pm[1] ? st.current_page : 8'h00;
	assign xpage = (pm == 2'd2) ? st.index_page : (pm[0] ? st.stack_page : 8'h00);
	assign raw = {instr.opcode_byte[3:0], instr.operand_one};
	assign inc = (ent.mode == M_RJMP) ? 16'd1 : 16'd2;
	assign rel_sum = instr.instr_address + inc + {{4{raw[11]}}, raw};

	always_comb begin
		case (instr.opcode_byte)
			OP_AND_F: nf = st.flag_byte & instr.operand_one;
			OP_OR_F:  nf = st.flag_byte | instr.operand_one;
			default:  nf = st.flag_byte ^ instr.operand_one;
		endcase
	end

	always_comb begin
		res = '0;
		res.instr_length = ent.len;
		res.cycle_count = ent.cyc;
		res.operand_mode = ent.mode;
		res.register_bank = xio;
		res.page_mode = pm;
		upd = '0;
		upd.flag_nxt = nf;
		upd.page_val = instr.operand_two;
		case (ent.mode)
			M_IMM: res.immediate_value = instr.operand_one;
			M_DIR, M_IND: res.first_address = {dpage, instr.operand_one};
			M_IDX: res.first_address = {xpage, instr.operand_one};
			M_DIMM: begin
				res.first_address = {dpage, instr.operand_one};
				res.immediate_value = instr.operand_two;
			end
			M_XIMM: begin
				res.first_address = {xpage, instr.operand_one};
				res.immediate_value = instr.operand_two;
			end
			M_DD: begin
				res.first_address = {dpage, instr.operand_one};
				res.second_address = {dpage, instr.operand_two};
			end
			M_RDIR, M_RIDX: res.first_address = {8'h00, instr.operand_one};
			M_RDIMM, M_RXIMM: begin
				res.first_address = {8'h00, instr.operand_one};
				res.immediate_value = instr.operand_two;
			end
			M_FLAG: begin
				res.immediate_value = instr.operand_one;
				res.page_mode = nf[7:6];
				res.page_mode_changed = (nf[7:6] != pm);
				upd.flag_we = 1'b1;
			end
			M_ABS: res.jump_target = {instr.operand_one, instr.operand_two} & AMASK;
			M_RJMP, M_RCALL: res.jump_target = rel_sum & AMASK;
			default: ;
		endcase
		if (instr.opcode_byte == OP_MOV_REG_IMM && !xio) begin
			upd.cur_we = (instr.operand_one == REG_CUR_PP);
			upd.stk_we = (instr.operand_one == REG_STK_PP);
			upd.idx_we = (instr.operand_one == REG_IDX_PP);
		end
	end

endmodule

@@ rtl/core/ipp_state.sv @@
// Flag byte and page pointer registers, updated as each transaction leaves decode.
module ipp_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  ipp_pkg::state_upd_t  upd,
	output ipp_pkg::page_state_t st
);
	import ipp_pkg::*;

	page_state_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			if (upd.flag_we) begin
				st_q.flag_byte <= upd.flag_nxt;
			end
			if (upd.cur_we) begin
				st_q.current_page <= upd.page_val;
			end
			if (upd.stk_we) begin
				st_q.stack_page <= upd.page_val;
			end
			if (upd.idx_we) begin
				st_q.index_page <= upd.page_val;
			end
		end
	end

	assign st = st_q;

endmodule

@@ bench/instruction_predecode_paging_test.sv @@
// Self-checking testbench for the paged instruction predecoder: directed table, then random traffic.
module instruction_predecode_paging_test;
	import ipp_pkg::*;

	localparam int ADDR_BITS = ADDRESS_BITS_DEF;
	localparam logic [31:0] ADDR_MASK = (32'd1 << ADDR_BITS) - 32'd1;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 60;
	localparam int DIRECTED_ROWS = 26;

	localparam logic [7:0] OP_SSC         = 8'h00;
	localparam logic [7:0] OP_ADD_A_IMM   = 8'h01;
	localparam logic [7:0] OP_ADD_A_DIR   = 8'h02;
	localparam logic [7:0] OP_ADD_A_IDX   = 8'h03;
	localparam logic [7:0] OP_ADD_DIR_IMM = 8'h06;
	localparam logic [7:0] OP_ADD_IDX_IMM = 8'h07;
	localparam logic [7:0] OP_CMP_A_DIR   = 8'h3a;
	localparam logic [7:0] OP_MVI_A_PINC  = 8'h3e;
	localparam logic [7:0] OP_OR_REG_IMM  = 8'h43;
	localparam logic [7:0] OP_MOV_DIR_DIR = 8'h5f;
	localparam logic [7:0] OP_MOV_REGX_A  = 8'h61;
	localparam logic [7:0] OP_XOR_F       = 8'h72;
	localparam logic [7:0] OP_LJMP        = 8'h7c;
	localparam logic [7:0] OP_JMP_FWD     = 8'h87;
	localparam logic [7:0] OP_JMP_BACK    = 8'h88;
	localparam logic [7:0] OP_INDEX_TOP   = 8'hff;
	localparam logic [7:0] REG_UNUSED_PP  = 8'hd2;

	typedef struct packed {
		logic [3:0] cyc;
		logic [1:0] len;
		logic [4:0] mode;
	} decode_slot_t;

	typedef struct packed {
		instr_t  ins;
		logic    typed;
		result_t want;
	} directed_row_t;

	localparam result_t NO_RESULT = '0;

	localparam decode_slot_t DECODE_ROM [0:135] = '{
		{4'd15, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd4, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd4, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd5, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd5, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd11, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd9, 2'd1, M_NONE}, {4'd4, 2'd2, M_IMM}, {4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd9, 2'd3, M_DIMM}, {4'd10, 2'd3, M_XIMM},
		{4'd5, 2'd2, M_IMM}, {4'd5, 2'd2, M_IMM}, {4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX},
		{4'd8, 2'd3, M_DIMM}, {4'd9, 2'd3, M_XIMM}, {4'd10, 2'd2, M_IND}, {4'd10, 2'd2, M_IND},
		{4'd4, 2'd1, M_NONE}, {4'd9, 2'd3, M_RDIMM}, {4'd10, 2'd3, M_RXIMM}, {4'd9, 2'd3, M_RDIMM},
		{4'd10, 2'd3, M_RXIMM}, {4'd9, 2'd3, M_RDIMM}, {4'd10, 2'd3, M_RXIMM}, {4'd7, 2'd3, M_DIMM},
		{4'd9, 2'd3, M_XIMM}, {4'd9, 2'd3, M_RDIMM}, {4'd10, 2'd3, M_RXIMM}, {4'd5, 2'd1, M_NONE},
		{4'd7, 2'd2, M_DIR}, {4'd7, 2'd2, M_DIR}, {4'd5, 2'd1, M_NONE}, {4'd4, 2'd1, M_NONE},
		{4'd4, 2'd2, M_IMM}, {4'd5, 2'd2, M_DIR}, {4'd6, 2'd2, M_IDX}, {4'd5, 2'd2, M_DIR},
		{4'd6, 2'd2, M_IDX}, {4'd8, 2'd3, M_DIMM}, {4'd9, 2'd3, M_XIMM}, {4'd4, 2'd2, M_IMM},
		{4'd6, 2'd2, M_DIR}, {4'd7, 2'd2, M_IDX}, {4'd5, 2'd2, M_DIR}, {4'd4, 2'd1, M_NONE},
		{4'd4, 2'd1, M_NONE}, {4'd6, 2'd2, M_RDIR}, {4'd7, 2'd2, M_RIDX}, {4'd10, 2'd3, M_DD},
		{4'd5, 2'd2, M_RDIR}, {4'd6, 2'd2, M_RIDX}, {4'd8, 2'd3, M_RDIMM}, {4'd9, 2'd3, M_RXIMM},
		{4'd4, 2'd1, M_NONE}, {4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd4, 2'd1, M_NONE},
		{4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX}, {4'd4, 2'd1, M_NONE}, {4'd7, 2'd2, M_DIR},
		{4'd8, 2'd2, M_IDX}, {4'd4, 2'd1, M_NONE}, {4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX},
		{4'd4, 2'd2, M_FLAG}, {4'd4, 2'd2, M_FLAG}, {4'd4, 2'd2, M_FLAG}, {4'd4, 2'd1, M_NONE},
		{4'd4, 2'd1, M_NONE}, {4'd4, 2'd1, M_NONE}, {4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX},
		{4'd4, 2'd1, M_NONE}, {4'd4, 2'd1, M_NONE}, {4'd7, 2'd2, M_DIR}, {4'd8, 2'd2, M_IDX},
		{4'd13, 2'd3, M_ABS}, {4'd7, 2'd3, M_ABS}, {4'd10, 2'd1, M_RET}, {4'd8, 2'd1, M_RET},
		{4'd5, 2'd2, M_RJMP}, {4'd11, 2'd2, M_RCALL}, {4'd5, 2'd2, M_RJMP}, {4'd5, 2'd2, M_RJMP},
		{4'd5, 2'd2, M_RJMP}, {4'd5, 2'd2, M_RJMP}, {4'd7, 2'd2, M_RJMP}, {4'd13, 2'd2, M_RCALL}
	};

	localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		{{16'h0000, OP_SSC, 8'h00, 8'h00}, 1'b1,
			{2'd1, 4'd15, M_NONE, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'd0, 1'b0}},
		{{16'hffff, OP_INDEX_TOP, 8'hff, 8'hff}, 1'b1,
			{2'd2, 4'd13, M_RCALL, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0000, 2'd0, 1'b0}},
		{{16'h1000, OP_JMP_FWD, 8'hff, 8'h00}, 1'b1,
			{2'd2, 4'd5, M_RJMP, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h1800, 2'd0, 1'b0}},
		{{16'h0800, OP_JMP_BACK, 8'h00, 8'h00}, 1'b1,
			{2'd2, 4'd5, M_RJMP, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'h0001, 2'd0, 1'b0}},
		{{16'h0000, OP_LJMP, 8'hab, 8'hcd}, 1'b1,
			{2'd3, 4'd13, M_ABS, 16'h0000, 16'h0000, 8'h00, 1'b0, 16'habcd, 2'd0, 1'b0}},
		{{16'h0000, OP_OR_F, 8'hc0, 8'h00}, 1'b1,
			{2'd2, 4'd4, M_FLAG, 16'h0000, 16'h0000, 8'hc0, 1'b0, 16'h0000, 2'd3, 1'b1}},
		{{16'h0100, OP_MOV_REG_IMM, REG_CUR_PP, 8'h12}, 1'b0, NO_RESULT},
		{{16'h0103, OP_MOV_REG_IMM, REG_STK_PP, 8'h34}, 1'b0, NO_RESULT},
		{{16'h0106, OP_MOV_REG_IMM, REG_IDX_PP, 8'h56}, 1'b0, NO_RESULT},
		{{16'h0109, OP_MOV_REG_IMM, REG_UNUSED_PP, 8'h9a}, 1'b0, NO_RESULT},
		{{16'h010c, OP_ADD_A_DIR, 8'h44, 8'hee}, 1'b0, NO_RESULT},
		{{16'h010e, OP_ADD_A_IDX, 8'h10, 8'h00}, 1'b0, NO_RESULT},
		{{16'h0110, OP_MOV_DIR_DIR, 8'h01, 8'h02}, 1'b0, NO_RESULT},
		{{16'h0113, OP_MVI_A_PINC, 8'h20, 8'h00}, 1'b0, NO_RESULT},
		{{16'h0115, OP_AND_F, 8'hbf, 8'h00}, 1'b0, NO_RESULT},
		{{16'h0117, OP_ADD_IDX_IMM, 8'h30, 8'h77}, 1'b0, NO_RESULT},
		{{16'h011a, OP_ADD_DIR_IMM, 8'h31, 8'h88}, 1'b0, NO_RESULT},
		{{16'h011d, OP_XOR_F, 8'h90, 8'h00}, 1'b0, NO_RESULT},
		{{16'h011f, OP_MOV_REG_IMM, REG_CUR_PP, 8'hff}, 1'b0, NO_RESULT},
		{{16'h0122, OP_XOR_F, 8'h50, 8'h00}, 1'b0, NO_RESULT},
		{{16'h0124, OP_ADD_A_IDX, 8'h99, 8'h00}, 1'b0, NO_RESULT},
		{{16'h0126, OP_OR_REG_IMM, REG_CUR_PP, 8'h0f}, 1'b0, NO_RESULT},
		{{16'h0129, OP_MOV_REGX_A, 8'h05, 8'h00}, 1'b0, NO_RESULT},
		{{16'h012b, OP_CMP_A_DIR, 8'h7f, 8'h55}, 1'b0, NO_RESULT},
		{{16'h012d, OP_ADD_A_IMM, 8'h5a, 8'h00}, 1'b0, NO_RESULT},
		{{16'h0200, OP_AND_F, 8'h00, 8'h00}, 1'b0, NO_RESULT}
	};

	logic        clk;
	logic        arst_n;
	logic        instr_valid;
	logic        instr_stall;
	logic [15:0] instr_address;
	logic [7:0]  opcode_byte;
	logic [7:0]  operand_one;
	logic [7:0]  operand_two;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  instr_length;
	logic [3:0]  cycle_count;
	logic [4:0]  operand_mode;
	logic [15:0] first_address;
	logic [15:0] second_address;
	logic [7:0]  immediate_value;
	logic        register_bank;
	logic [15:0] jump_target;
	logic [1:0]  page_mode;
	logic        page_mode_changed;

	logic [7:0] flag_q;
	logic [7:0] cur_page_q;
	logic [7:0] stk_page_q;
	logic [7:0] idx_page_q;

	result_t pending_results [$];
	int      error_count;
	int      quiet_cycles;
	bit      calm;
	bit      long_hold_req;

	instruction_predecode_paging uut (
		.clk(clk),
		.arst_n(arst_n),
		.instr_valid(instr_valid),
		.instr_stall(instr_stall),
		.instr_address(instr_address),
		.opcode_byte(opcode_byte),
		.operand_one(operand_one),
		.operand_two(operand_two),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.instr_length(instr_length),
		.cycle_count(cycle_count),
		.operand_mode(operand_mode),
		.first_address(first_address),
		.second_address(second_address),
		.immediate_value(immediate_value),
		.register_bank(register_bank),
		.jump_target(jump_target),
		.page_mode(page_mode),
		.page_mode_changed(page_mode_changed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic predecode(input instr_t ins, output result_t res);
		decode_slot_t row;
		logic [7:0]   slot;
		logic [7:0]   dpage;
		logic [7:0]   xpage;
		logic [7:0]   nf;
		logic [7:0]   b1;
		logic [7:0]   b2;
		logic [1:0]   pm;
		logic         xio;
		logic [11:0]  rel;
		logic [31:0]  tgt;
		b1 = ins.operand_one;
		b2 = ins.operand_two;
		slot = ins.opcode_byte[7] ? FOLD_BASE + {4'd0, ins.opcode_byte[7:4]} : ins.opcode_byte;
		row = DECODE_ROM[slot];
		pm = flag_q[7:6];
		xio = flag_q[4];
		dpage = pm[1] ? cur_page_q : 8'h00;
		xpage = (pm == 2'd2) ? idx_page_q : (pm[0] ? stk_page_q : 8'h00);
		res = '0;
		res.instr_length = row.len;
		res.cycle_count = row.cyc;
		res.operand_mode = row.mode;
		res.register_bank = xio;
		case (row.mode)
			M_IMM: res.immediate_value = b1;
			M_DIR, M_IND: res.first_address = {dpage, b1};
			M_IDX: res.first_address = {xpage, b1};
			M_DIMM: begin
				res.first_address = {dpage, b1};
				res.immediate_value = b2;
			end
			M_XIMM: begin
				res.first_address = {xpage, b1};
				res.immediate_value = b2;
			end
			M_DD: begin
				res.first_address = {dpage, b1};
				res.second_address = {dpage, b2};
			end
			M_RDIR, M_RIDX: res.first_address = {8'h00, b1};
			M_RDIMM, M_RXIMM: begin
				res.first_address = {8'h00, b1};
				res.immediate_value = b2;
			end
			M_FLAG: begin
				if (ins.opcode_byte == OP_AND_F)
					nf = flag_q & b1;
				else if (ins.opcode_byte == OP_OR_F)
					nf = flag_q | b1;
				else
					nf = flag_q ^ b1;
				res.page_mode_changed = (nf[7:6] != pm);
				flag_q = nf;
				res.immediate_value = b1;
			end
			M_ABS: begin
				tgt = {16'h0000, b1, b2} & ADDR_MASK;
				res.jump_target = tgt[15:0];
			end
			M_RJMP, M_RCALL: begin
				rel = {ins.opcode_byte[3:0], b1};
				tgt = {16'h0000, ins.instr_address} + ((row.mode == M_RJMP) ? 32'd1 : 32'd2)
					+ {{20{rel[11]}}, rel};
				tgt = tgt & ADDR_MASK;
				res.jump_target = tgt[15:0];
			end
			default: ;
		endcase
		if (ins.opcode_byte == OP_MOV_REG_IMM && !xio) begin
			case (b1)
				REG_CUR_PP: cur_page_q = b2;
				REG_STK_PP: stk_page_q = b2;
				REG_IDX_PP: idx_page_q = b2;
				default: ;
			endcase
		end
		res.page_mode = flag_q[7:6];
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		int     pick;
		ins.instr_address = 16'($urandom_range(0, 65535));
		ins.opcode_byte = 8'($urandom_range(0, 255));
		ins.operand_one = 8'($urandom_range(0, 255));
		ins.operand_two = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			case ($urandom_range(0, 2))
				0: ins.opcode_byte = OP_AND_F;
				1: ins.opcode_byte = OP_OR_F;
				default: ins.opcode_byte = OP_XOR_F;
			endcase
		end else if (pick < 30) begin
			ins.opcode_byte = OP_MOV_REG_IMM;
			case ($urandom_range(0, 4))
				0: ins.operand_one = REG_CUR_PP;
				1: ins.operand_one = REG_STK_PP;
				2: ins.operand_one = REG_IDX_PP;
				default: ;
			endcase
		end
		return ins;
	endfunction

	task automatic send_instr(input instr_t ins, input int gap, input logic typed,
		input result_t want);
		result_t pred;
		if (gap > 0) begin
			instr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_valid <= 1'b1;
		instr_address <= ins.instr_address;
		opcode_byte <= ins.opcode_byte;
		operand_one <= ins.operand_one;
		operand_two <= ins.operand_two;
		@(posedge clk);
		while (instr_stall)
			@(posedge clk);
		predecode(ins, pred);
		pending_results.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t due;
		if (arst_n && ((instr_valid && !instr_stall) || (result_valid && !result_stall)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transaction with nothing expected", $time);
				error_count++;
			end else begin
				due = pending_results.pop_front();
				check_field("instr_length", 16'(due.instr_length), 16'(instr_length));
				check_field("cycle_count", 16'(due.cycle_count), 16'(cycle_count));
				check_field("operand_mode", 16'(due.operand_mode), 16'(operand_mode));
				check_field("first_address", due.first_address, first_address);
				check_field("second_address", due.second_address, second_address);
				check_field("immediate_value", 16'(due.immediate_value),
					16'(immediate_value));
				check_field("register_bank", 16'(due.register_bank), 16'(register_bank));
				check_field("jump_target", due.jump_target, jump_target);
				check_field("page_mode", 16'(due.page_mode), 16'(page_mode));
				check_field("page_mode_changed", 16'(due.page_mode_changed),
					16'(page_mode_changed));
			end
		end
	end

	initial begin
		int hold_left;
		int g;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				result_stall <= 1'b1;
			end else if (calm) begin
				result_stall <= 1'b0;
			end else begin
				g = random_gap();
				result_stall <= (g > 0);
				if (g > 0)
					hold_left = g - 1;
			end
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		instr_valid = 1'b0;
		instr_address = 16'h0000;
		opcode_byte = 8'h00;
		operand_one = 8'h00;
		operand_two = 8'h00;
		flag_q = 8'h00;
		cur_page_q = 8'h00;
		stk_page_q = 8'h00;
		idx_page_q = 8'h00;
		error_count = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		long_hold_req = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_instr(DIRECTED[i].ins, random_gap(), DIRECTED[i].typed, DIRECTED[i].want);

		repeat (300) send_instr(random_instr(), random_gap(), 1'b0, NO_RESULT);

		// hold the output while the input keeps offering
		long_hold_req = 1'b1;
		repeat (20) send_instr(random_instr(), 0, 1'b0, NO_RESULT);

		// drain before resuming
		instr_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (4) @(negedge clk);

		calm = 1'b1;
		repeat (150) send_instr(random_instr(), 0, 1'b0, NO_RESULT);
		calm = 1'b0;

		repeat (480) send_instr(random_instr(), random_gap(), 1'b0, NO_RESULT);

		instr_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
